// ===== src/mlem_pkg.sv =====
// Shared types, codes and constants for the MLEM ray update engine.
package mlem_pkg;

    localparam int GRID_SIZE_DEF    = 128;
    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int DIV_STEPS        = 32;
    localparam int LEN_FRAC         = 14;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_SEG   = 2'd1;
    localparam logic [1:0] ACT_APPLY = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_RAY   = 2'd1;
    localparam logic [1:0] KIND_APPLY = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] pixel_index;
        logic [15:0] seg_length;
        logic [31:0] pixel_value;
        logic [31:0] ray_value;
        logic        last_segment;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] read_value;
        logic [31:0] projection;
        logic        zero_projection;
        logic        segments_dropped;
    } res_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_SEG,
        S_READ,
        S_READ_OUT,
        S_FP_SEG,
        S_FP_IMG,
        S_FP_MUL,
        S_FP_ACC,
        S_DIV_START,
        S_DIV_WAIT,
        S_BP_SEG,
        S_BP_RD,
        S_BP_MUL,
        S_BP_WR,
        S_RAY_OUT,
        S_AP_RD,
        S_AP_MUL,
        S_AP_DIV,
        S_AP_WAIT,
        S_AP_OUT
    } state_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== src/mlem_ray_update_engine_core.sv =====
// Top level of the MLEM ray update engine: sequencer, stores and shared multiplier.
//
// Usage: drive command and raise start; the word is taken at a clock edge where
// start is high and busy is low. busy stays high while the word is worked on.
// Results appear on result for exactly one cycle with result_valid high; the
// receiver cannot stall, so each result must be taken in that cycle.
// Steps per word:
//   write pixel: S_WRITE; non-last segment: S_SEG; read pixel: S_READ, S_READ_OUT.
//   last segment: forward projection over the N kept segments, the divider (skipped
//     for a zero projection), the scatter-add over the segments, then the report.
//   apply update: per pixel a read and a multiply, then, when its sensitivity is not
//     zero, the 32-step divider; NPIX pixels in turn, then the report.
// The shared 32x32 multiplier and the one-bit-a-cycle divider set these loops.
// Reset: after rst_n rises the sensitivity and weighted stores are cleared, one
// entry a cycle, for GRID_SIZE*GRID_SIZE cycles with busy high. The image store
// and the segment buffer hold garbage until written.
module mlem_ray_update_engine_core
    import mlem_pkg::*;
#(
    parameter int GRID_SIZE    = GRID_SIZE_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t command,
    output logic result_valid,
    output res_t result
);

    localparam int unsigned NPIX = GRID_SIZE * GRID_SIZE;
    localparam int PIX_W  = $clog2(NPIX);
    localparam int SEG_AW = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

    state_t state_reg;
    state_t state_next;

    cmd_t             cmd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [63:0]      acc_reg;
    logic [63:0]      prod_reg;
    logic [31:0]      proj_reg;
    logic             zero_reg;
    logic [31:0]      corr_reg;
    logic [PIX_W-1:0] cur_idx_reg;
    logic [15:0]      cur_len_reg;
    logic             cur_inr_reg;
    logic [31:0]      sens_reg;
    logic [31:0]      wold_reg;
    logic             valid_reg;
    res_t             result_reg;

    logic             img_we, sens_we, wt_we, seg_we;
    logic [PIX_W-1:0] img_waddr, img_raddr, st_waddr, st_raddr;
    logic [31:0]      img_wdata, sens_wdata, wt_wdata, img_rdata, sens_rdata, wt_rdata;
    logic [31:0]      seg_wdata, seg_rdata;
    logic [SEG_AW-1:0] seg_waddr, seg_raddr;
    logic [31:0]      mul_a, mul_b;
    logic             div_start, div_done;
    logic [63:0]      div_dividend;
    logic [31:0]      div_divisor, div_q;

    logic             cmd_inr, seg_inr, pix_last, seg_room;
    logic [31:0]      proj_c, wt_add;

    assign cmd_inr  = 32'(cmd_reg.pixel_index) < NPIX;
    assign seg_inr  = 32'(seg_rdata[31:16]) < NPIX;
    assign pix_last = pix_reg == PIX_W'(NPIX - 1);
    assign seg_room = cnt_reg < CNT_W'(MAX_SEGMENTS);
    assign proj_c   = (|acc_reg[63:46]) ? 32'hFFFF_FFFF : acc_reg[45:14];
    assign wt_add   = (|prod_reg[63:46]) ? 32'hFFFF_FFFF : prod_reg[45:14];

    mlem_ram #(.DEPTH(NPIX), .WIDTH(32)) u_img (
        .clk(clk), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
        .raddr(img_raddr), .rdata(img_rdata)
    );

    mlem_ram #(.DEPTH(NPIX), .WIDTH(32)) u_sens (
        .clk(clk), .we(sens_we), .waddr(st_waddr), .wdata(sens_wdata),
        .raddr(st_raddr), .rdata(sens_rdata)
    );

    mlem_ram #(.DEPTH(NPIX), .WIDTH(32)) u_wt (
        .clk(clk), .we(wt_we), .waddr(st_waddr), .wdata(wt_wdata),
        .raddr(st_raddr), .rdata(wt_rdata)
    );

    mlem_ram #(.DEPTH(MAX_SEGMENTS), .WIDTH(32)) u_seg (
        .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
        .raddr(seg_raddr), .rdata(seg_rdata)
    );

    mlem_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .done(div_done), .quotient(div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:     state_next = pix_last ? S_IDLE : S_CLEAR;
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (command.action)
                        ACT_WRITE: state_next = S_WRITE;
                        ACT_SEG:   state_next = S_SEG;
                        ACT_APPLY: state_next = S_AP_RD;
                        ACT_READ:  state_next = S_READ;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE:     state_next = S_IDLE;
            S_SEG:       state_next = cmd_reg.last_segment ? S_FP_SEG : S_IDLE;
            S_READ:      state_next = S_READ_OUT;
            S_READ_OUT:  state_next = S_IDLE;
            S_FP_SEG:    state_next = (ptr_reg == cnt_reg) ? S_DIV_START : S_FP_IMG;
            S_FP_IMG:    state_next = S_FP_MUL;
            S_FP_MUL:    state_next = S_FP_ACC;
            S_FP_ACC:    state_next = S_FP_SEG;
            S_DIV_START: state_next = (proj_c == 32'd0) ? S_BP_SEG : S_DIV_WAIT;
            S_DIV_WAIT:  state_next = div_done ? S_BP_SEG : S_DIV_WAIT;
            S_BP_SEG:    state_next = (ptr_reg == cnt_reg) ? S_RAY_OUT : S_BP_RD;
            S_BP_RD:     state_next = S_BP_MUL;
            S_BP_MUL:    state_next = S_BP_WR;
            S_BP_WR:     state_next = S_BP_SEG;
            S_RAY_OUT:   state_next = S_IDLE;
            S_AP_RD:     state_next = S_AP_MUL;
            S_AP_MUL:
            begin
                if (sens_rdata != 32'd0)
                begin
                    state_next = S_AP_DIV;
                end
                else
                begin
                    state_next = pix_last ? S_AP_OUT : S_AP_RD;
                end
            end
            S_AP_DIV:    state_next = S_AP_WAIT;
            S_AP_WAIT:
            begin
                if (div_done)
                begin
                    state_next = pix_last ? S_AP_OUT : S_AP_RD;
                end
            end
            S_AP_OUT:    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        img_we       = 1'b0;
        img_waddr    = cmd_reg.pixel_index[PIX_W-1:0];
        img_wdata    = cmd_reg.pixel_value;
        img_raddr    = cmd_reg.pixel_index[PIX_W-1:0];
        sens_we      = 1'b0;
        wt_we        = 1'b0;
        st_waddr     = cur_idx_reg;
        st_raddr     = seg_rdata[16+PIX_W-1:16];
        sens_wdata   = sat_add32(sens_rdata, {14'd0, cur_len_reg, 2'b00});
        wt_wdata     = sat_add32(wold_reg, wt_add);
        seg_we       = 1'b0;
        seg_waddr    = cnt_reg[SEG_AW-1:0];
        seg_wdata    = {cmd_reg.pixel_index, cmd_reg.seg_length};
        seg_raddr    = ptr_reg[SEG_AW-1:0];
        mul_a        = img_rdata;
        mul_b        = {16'd0, cur_len_reg};
        div_start    = 1'b0;
        div_dividend = prod_reg;
        div_divisor  = sens_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                sens_we    = 1'b1;
                wt_we      = 1'b1;
                st_waddr   = pix_reg;
                sens_wdata = 32'd0;
                wt_wdata   = 32'd0;
            end
            S_WRITE:     img_we = cmd_inr;
            S_SEG:       seg_we = seg_room;
            S_FP_IMG:    img_raddr = seg_rdata[16+PIX_W-1:16];
            S_DIV_START:
            begin
                div_start    = proj_c != 32'd0;
                div_dividend = {16'd0, cmd_reg.ray_value, 16'd0};
                div_divisor  = proj_c;
            end
            S_BP_MUL:
            begin
                mul_a   = corr_reg;
                sens_we = cur_inr_reg;
            end
            S_BP_WR:     wt_we = cur_inr_reg && !zero_reg;
            S_AP_RD:
            begin
                img_raddr = pix_reg;
                st_raddr  = pix_reg;
            end
            S_AP_MUL:
            begin
                mul_b      = wt_rdata;
                sens_we    = 1'b1;
                wt_we      = 1'b1;
                st_waddr   = pix_reg;
                sens_wdata = 32'd0;
                wt_wdata   = 32'd0;
            end
            S_AP_DIV:    div_start = 1'b1;
            S_AP_WAIT:
            begin
                img_we    = div_done;
                img_waddr = pix_reg;
                img_wdata = div_q;
            end
            default:     img_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            ptr_reg   <= '0;
            pix_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == S_READ_OUT) || (state_reg == S_RAY_OUT)
                         || (state_reg == S_AP_OUT);
            case (state_reg)
                S_CLEAR:     pix_reg <= pix_reg + 1'b1;
                S_IDLE:
                begin
                    ptr_reg <= '0;
                    pix_reg <= '0;
                end
                S_SEG:
                begin
                    if (seg_room)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                S_FP_ACC, S_BP_WR: ptr_reg <= ptr_reg + 1'b1;
                S_DIV_START: ptr_reg <= '0;
                S_RAY_OUT:
                begin
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                S_AP_MUL:
                begin
                    if (sens_rdata == 32'd0)
                    begin
                        pix_reg <= pix_reg + 1'b1;
                    end
                end
                S_AP_WAIT:
                begin
                    if (div_done)
                    begin
                        pix_reg <= pix_reg + 1'b1;
                    end
                end
                default:     ptr_reg <= ptr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg <= command;
                acc_reg <= 64'd0;
            end
            S_FP_IMG, S_BP_RD:
            begin
                cur_idx_reg <= seg_rdata[16+PIX_W-1:16];
                cur_len_reg <= seg_rdata[15:0];
                cur_inr_reg <= seg_inr;
            end
            S_FP_MUL:    prod_reg <= cur_inr_reg ? (mul_a * mul_b) : 64'd0;
            S_FP_ACC:    acc_reg <= acc_reg + prod_reg;
            S_DIV_START:
            begin
                proj_reg <= proj_c;
                zero_reg <= proj_c == 32'd0;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    corr_reg <= div_q;
                end
            end
            S_BP_MUL:
            begin
                prod_reg <= mul_a * mul_b;
                wold_reg <= wt_rdata;
            end
            S_AP_MUL:
            begin
                prod_reg <= mul_a * mul_b;
                sens_reg <= sens_rdata;
            end
            S_READ_OUT:
            begin
                result_reg.result_kind      <= KIND_READ;
                result_reg.read_value       <= cmd_inr ? img_rdata : 32'd0;
                result_reg.projection       <= 32'd0;
                result_reg.zero_projection  <= 1'b0;
                result_reg.segments_dropped <= 1'b0;
            end
            S_RAY_OUT:
            begin
                result_reg.result_kind      <= KIND_RAY;
                result_reg.read_value       <= 32'd0;
                result_reg.projection       <= proj_reg;
                result_reg.zero_projection  <= zero_reg;
                result_reg.segments_dropped <= ovf_reg;
            end
            S_AP_OUT:
            begin
                result_reg.result_kind      <= KIND_APPLY;
                result_reg.read_value       <= 32'd0;
                result_reg.projection       <= 32'd0;
                result_reg.zero_projection  <= 1'b0;
                result_reg.segments_dropped <= 1'b0;
            end
            default:     wold_reg <= wold_reg;
        endcase
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== src/mlem_ram.sv =====
// Single write port, single registered read port memory.
module mlem_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/mlem_div.sv =====
// Iterative saturating divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
module mlem_div
    import mlem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       q_reg;
    logic [31:0]       dsr_reg;
    logic [32:0]       trial;
    logic              fits;

    assign trial = {rem_reg, q_reg[31]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                if (dividend[63:32] >= divisor)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            rem_reg <= dividend[63:32];
            q_reg   <= (dividend[63:32] >= divisor) ? 32'hFFFF_FFFF : dividend[31:0];
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
            q_reg   <= {q_reg[30:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/mlem_chk.sv =====
// Port-level checker for the MLEM ray update engine, bound to the top level.
module mlem_chk
    import mlem_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input res_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.result_kind == KIND_READ || result.result_kind == KIND_RAY
                          || result.result_kind == KIND_APPLY))
        else $error("bad result kind");

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == KIND_READ
        |-> !result.zero_projection && !result.segments_dropped && result.projection == 32'd0)
        else $error("read result carries ray fields");

endmodule

bind mlem_ray_update_engine_core mlem_chk u_mlem_chk (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .result_valid(result_valid),
    .result(result)
);

// ===== tb/mlem_checker.sv =====
// Checker for the MLEM ray update engine: predicts result words and compares them.
`timescale 1ns / 1ps
module mlem_checker
    import mlem_pkg::*;
#(
    parameter int GRID_SIZE    = 128,
    parameter int MAX_SEGMENTS = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  cmd_t command,
    input  logic result_valid,
    input  res_t result,
    output int   errors,
    output int   pending
);

    localparam int NPIX = GRID_SIZE * GRID_SIZE;

    logic [31:0] image_px  [NPIX];
    logic [31:0] weight_sum[NPIX];
    logic [31:0] sens_sum  [NPIX];
    logic [15:0] ray_ix    [MAX_SEGMENTS];
    logic [15:0] ray_len   [MAX_SEGMENTS];
    int          seg_cnt;
    bit          seg_overflow;
    res_t        expected_words[$];

    initial
    begin
        for (int i = 0; i < NPIX; i++)
        begin
            image_px[i]   = '0;
            weight_sum[i] = '0;
            sens_sum[i]   = '0;
        end
        seg_cnt      = 0;
        seg_overflow = 0;
        errors       = 0;
        pending      = 0;
    end

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    function automatic res_t trace_ray(input logic [31:0] ray);
        logic [63:0] acc;
        logic [31:0] proj;
        logic [31:0] corr;
        logic [31:0] len;
        res_t        r;
        acc  = '0;
        corr = '0;
        for (int i = 0; i < seg_cnt; i++)
            if (ray_ix[i] < NPIX)
                acc += {32'b0, image_px[ray_ix[i]]} * {48'b0, ray_len[i]};
        proj = sat32(acc >> LEN_FRAC);
        if (proj != 0)
            corr = sat32(({32'b0, ray} << 16) / {32'b0, proj});
        for (int i = 0; i < seg_cnt; i++)
        begin
            if (ray_ix[i] < NPIX)
            begin
                len = {16'b0, ray_len[i]};
                sens_sum[ray_ix[i]] = sat32({32'b0, sens_sum[ray_ix[i]]} + {30'b0, len, 2'b0});
                if (proj != 0)
                    weight_sum[ray_ix[i]] = sat32({32'b0, weight_sum[ray_ix[i]]}
                        + {32'b0, sat32(({32'b0, len} * {32'b0, corr}) >> LEN_FRAC)});
            end
        end
        r                  = '0;
        r.result_kind      = KIND_RAY;
        r.projection       = proj;
        r.zero_projection  = (proj == 0);
        r.segments_dropped = seg_overflow;
        seg_cnt            = 0;
        seg_overflow       = 0;
        return r;
    endfunction

    function automatic void predict_word(input cmd_t c);
        res_t r;
        r = '0;
        case (c.action)
            ACT_WRITE:
                if (c.pixel_index < NPIX)
                    image_px[c.pixel_index] = c.pixel_value;
            ACT_SEG:
            begin
                if (seg_cnt < MAX_SEGMENTS)
                begin
                    ray_ix[seg_cnt]  = c.pixel_index;
                    ray_len[seg_cnt] = c.seg_length;
                    seg_cnt++;
                end
                else
                    seg_overflow = 1;
                if (c.last_segment)
                    expected_words.push_back(trace_ray(c.ray_value));
            end
            ACT_APPLY:
            begin
                for (int i = 0; i < NPIX; i++)
                begin
                    if (sens_sum[i] != 0)
                        image_px[i] = sat32(({32'b0, image_px[i]} * {32'b0, weight_sum[i]})
                                            / {32'b0, sens_sum[i]});
                    sens_sum[i]   = '0;
                    weight_sum[i] = '0;
                end
                r.result_kind = KIND_APPLY;
                expected_words.push_back(r);
            end
            default:
            begin
                r.result_kind = KIND_READ;
                r.read_value  = (c.pixel_index < NPIX) ? image_px[c.pixel_index] : 32'd0;
                expected_words.push_back(r);
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        res_t e;
        if (result_valid)
        begin
            if (expected_words.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                e = expected_words.pop_front();
                if (result.result_kind !== e.result_kind)
                    report_mismatch($sformatf("result_kind %0d, want %0d",
                                              result.result_kind, e.result_kind));
                if (result.read_value !== e.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              result.read_value, e.read_value));
                if (result.projection !== e.projection)
                    report_mismatch($sformatf("projection %h, want %h",
                                              result.projection, e.projection));
                if (result.zero_projection !== e.zero_projection)
                    report_mismatch($sformatf("zero_projection %b, want %b",
                                              result.zero_projection, e.zero_projection));
                if (result.segments_dropped !== e.segments_dropped)
                    report_mismatch($sformatf("segments_dropped %b, want %b",
                                              result.segments_dropped, e.segments_dropped));
            end
        end
        if (rst_n && start && !busy)
            predict_word(command);
        pending = expected_words.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the MLEM ray update engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import mlem_pkg::*;

    localparam int GRID_SIZE    = 128;
    localparam int MAX_SEGMENTS = 256;
    localparam int NPIX         = GRID_SIZE * GRID_SIZE;
    localparam int CYCLE_LIMIT  = 4000000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t command;
    logic result_valid;
    res_t result;
    int   errors;
    int   pending;
    int   cycles;
    int   written_px[$];

    mlem_ray_update_engine_core #(
        .GRID_SIZE   (GRID_SIZE),
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .result_valid(result_valid),
        .result      (result)
    );

    mlem_checker #(
        .GRID_SIZE   (GRID_SIZE),
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .result_valid(result_valid),
        .result      (result),
        .errors      (errors),
        .pending     (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic cmd_t make_word(input logic [1:0] act, input logic [15:0] ix,
                                       input logic [15:0] len, input logic [31:0] pv,
                                       input logic [31:0] rv, input logic last);
        cmd_t c;
        c.action       = act;
        c.pixel_index  = ix;
        c.seg_length   = len;
        c.pixel_value  = pv;
        c.ray_value    = rv;
        c.last_segment = last;
        return c;
    endfunction

    task automatic send_word(input cmd_t c);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= c;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        if (c.action == ACT_WRITE && c.pixel_index < NPIX)
            written_px.push_back(int'(c.pixel_index));
    endtask

    function automatic logic [15:0] pick_index();
        if (written_px.size() > 0 && $urandom_range(0, 99) < 88)
            return 16'(written_px[$urandom_range(0, written_px.size() - 1)]);
        return 16'($urandom_range(NPIX, 65535));
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom();
            default: return $urandom_range(0, 32'h3FFFF);
        endcase
    endfunction

    task automatic send_ray(input int n);
        for (int i = 0; i < n; i++)
            send_word(make_word(ACT_SEG, pick_index(), pick_length(), $urandom(),
                                $urandom(), i == n - 1));
    endtask

    initial
    begin
        int n;
        int sel;
        rst_n   = 1'b0;
        start   = 1'b0;
        command = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_word(make_word(ACT_WRITE, 16'd0, 16'h0, 32'h0, 32'h0, 1'b0));
        send_word(make_word(ACT_WRITE, 16'(NPIX - 1), 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            1'b1));
        send_word(make_word(ACT_WRITE, 16'hFFFF, 16'h0, 32'h1234_5678, 32'h0, 1'b0));
        send_word(make_word(ACT_WRITE, 16'd5, 16'h0, 32'h0001_0000, 32'h0, 1'b0));
        send_word(make_word(ACT_READ, 16'd0, 16'h0, 32'h0, 32'h0, 1'b0));
        send_word(make_word(ACT_READ, 16'(NPIX - 1), 16'h0, 32'h0, 32'h0, 1'b0));
        send_word(make_word(ACT_READ, 16'(NPIX), 16'h0, 32'h0, 32'h0, 1'b0));
        send_word(make_word(ACT_READ, 16'hFFFF, 16'h0, 32'h0, 32'h0, 1'b0));
        send_word(make_word(ACT_SEG, 16'd0, 16'h4000, 32'h0, 32'h0001_0000, 1'b1));
        send_word(make_word(ACT_SEG, 16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(ACT_SEG, 16'(NPIX - 1), 16'hFFFF, 32'h0, 32'h0, 1'b0));
        send_word(make_word(ACT_SEG, 16'(NPIX - 1), 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(ACT_SEG, 16'd5, 16'h4000, 32'h0, 32'h0, 1'b0));
        send_word(make_word(ACT_SEG, 16'(NPIX), 16'h4000, 32'h0, 32'h0, 1'b0));
        send_word(make_word(ACT_SEG, 16'd5, 16'h0000, 32'h0, 32'h0002_0000, 1'b1));
        send_word(make_word(ACT_APPLY, 16'h0, 16'h0, 32'h0, 32'h0, 1'b0));
        send_word(make_word(ACT_READ, 16'd5, 16'h0, 32'h0, 32'h0, 1'b0));
        send_word(make_word(ACT_READ, 16'(NPIX - 1), 16'h0, 32'h0, 32'h0, 1'b0));

        n = 0;
        while (n < 1700)
        begin
            sel = $urandom_range(0, 999);
            if (sel < 4)
            begin
                send_word(make_word(ACT_APPLY, 16'($urandom()), 16'($urandom()), $urandom(),
                                    $urandom(), 1'($urandom_range(0, 1))));
                n++;
            end
            else if (sel < 7)
            begin
                send_ray(MAX_SEGMENTS + $urandom_range(1, 8));
                n += MAX_SEGMENTS;
            end
            else if (sel < 250)
            begin
                send_word(make_word(ACT_WRITE, ($urandom_range(0, 9) == 0) ?
                                    16'($urandom_range(NPIX, 65535)) :
                                    16'($urandom_range(0, NPIX - 1)),
                                    16'($urandom()), pick_pixel(), $urandom(),
                                    1'($urandom_range(0, 1))));
                n++;
            end
            else if (sel < 370)
            begin
                send_word(make_word(ACT_READ, pick_index(), 16'($urandom()), $urandom(),
                                    $urandom(), 1'($urandom_range(0, 1))));
                n++;
            end
            else
            begin
                sel = $urandom_range(1, 8);
                send_ray(sel);
                n += sel;
            end
        end
        send_word(make_word(ACT_APPLY, 16'h0, 16'h0, 32'h0, 32'h0, 1'b0));
        start <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
src/mlem_pkg.sv
src/mlem_ram.sv
src/mlem_div.sv
src/mlem_ray_update_engine_core.sv
src/mlem_chk.sv
tb/mlem_checker.sv
tb/testbench.sv
